[rtl/hts_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the transform hierarchy solver.
// No dependencies; the files that use it refer to this package by scoped names.
package hts_pkg;

   localparam int NODE_COUNT_DEF    = 64;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int ROWS              = 4;
   localparam int WORD_W            = 32;

   typedef struct packed {
      logic [5:0]         node_number;
      logic [5:0]         parent_number;
      logic               is_root;
      logic [1:0]         column_number;
      logic signed [31:0] local_row0;
      logic signed [31:0] local_row1;
      logic signed [31:0] local_row2;
      logic signed [31:0] local_row3;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_node;
      logic [1:0]         out_column;
      logic signed [31:0] global_row0;
      logic signed [31:0] global_row1;
      logic signed [31:0] global_row2;
      logic signed [31:0] global_row3;
      logic               saturated;
   } rsp_type;

   // item as classified by the front end
   typedef struct packed {
      req_type item;
      logic    node_ok;
      logic    parent_ok;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ISSUE,
      BK_WAIT,
      BK_DONE
   } back_state_type;

endpackage

[rtl/hierarchy_transform_solver.sv]
`timescale 1ns / 1ps
// Top level of the transform hierarchy solver: front end, job queue, back end.
// Depends on hts_pkg, hts_front, hts_back (which holds the hts_ram global store).
//
//   channel | ports                             | payload
//   --------+-----------------------------------+-------------------
//   input   | req_valid, req_stall, req_data    | hts_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_data    | hts_pkg::rsp_type
//
// A root item skips the reads in the back end; for a child item, four single-port
// reads of the parent's columns feed four 32x32 multipliers, then round, accumulate.
// The front queue holds two items, so input is taken while the back end works.
// Synchronous active-high reset clears control; the store holds nothing until written.
// A stalled result holds in the output register; the back end waits for it to drain.
module hierarchy_transform_solver #(
   parameter int NODE_COUNT    = hts_pkg::NODE_COUNT_DEF,
   parameter int FRACTION_BITS = hts_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hts_pkg::rsp_type rsp_data
);

   logic             job_vld;
   logic             job_pop;
   hts_pkg::job_type job;

   hts_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_vld   (job_vld),
      .job       (job),
      .job_pop   (job_pop)
   );

   hts_back #(
      .NODE_COUNT    (NODE_COUNT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_vld   (job_vld),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // back end only takes a job that is there
   a_pop_has_job : assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_vld)
      else $error("job popped from empty queue");

   // an accepted item is queued or already handed over, never lost
   a_accept_queued : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> job_vld)
      else $error("accepted item missing from queue");

   // one job at a time: no pop in the cycle after a pop
   a_single_job : assert property (@(posedge clock) disable iff (reset)
      job_pop |=> !job_pop)
      else $error("back end took two jobs in a row");

endmodule

[rtl/hts_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/hts_front.sv]
`timescale 1ns / 1ps
// Front end: accepts items, flags out-of-range node and parent numbers, queues jobs for the back end.
// Depends on hts_pkg.
module hts_front #(
   parameter int NODE_COUNT = hts_pkg::NODE_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hts_pkg::req_type req_data,
   output logic             job_vld,
   output hts_pkg::job_type job,
   input  logic             job_pop
);

   localparam int QD = hts_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(QD);
   localparam int CW = $clog2(QD + 1);

   hts_pkg::job_type mem_ff [QD];
   hts_pkg::job_type job_in;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;

   always_comb begin
      job_in.item      = req_data;
      job_in.node_ok   = (32'(req_data.node_number) < NODE_COUNT);
      job_in.parent_ok = (32'(req_data.parent_number) < NODE_COUNT);
   end

   assign req_stall = (count_ff == CW'(QD));
   assign push      = req_valid && !req_stall;
   assign job_vld   = (count_ff != '0);
   assign job       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !job_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && job_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

[rtl/hts_back.sv]
`timescale 1ns / 1ps
// Back end: for a child item, reads the parent matrix column by column, multiplies,
// accumulates, saturates; writes the store and holds the result. Uses hts_pkg, hts_ram.
module hts_back #(
   parameter int NODE_COUNT    = hts_pkg::NODE_COUNT_DEF,
   parameter int FRACTION_BITS = hts_pkg::FRACTION_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_vld,
   input  hts_pkg::job_type job,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hts_pkg::rsp_type rsp_data
);

   localparam int NW    = $clog2(NODE_COUNT);
   localparam int AW    = NW + 2;
   localparam int DEPTH = NODE_COUNT * 4;
   localparam int WW    = hts_pkg::WORD_W;
   localparam int COL_W = hts_pkg::ROWS * WW;
   localparam int TW    = 64 - FRACTION_BITS;
   localparam int ACC_W = TW + 2;
   localparam logic signed [63:0]      HALF   = 64'sd1 <<< (FRACTION_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
   localparam logic [2:0]              TERMS  = 3'd4;

   hts_pkg::back_state_type state_ff, state_in;
   hts_pkg::job_type        job_ff;
   hts_pkg::rsp_type        rsp_ff, rsp_in;
   logic                    rsp_vld_ff;

   logic [1:0]              kcnt_ff, kcnt_in;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [COL_W-1:0]        rd_data;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [COL_W-1:0]        wr_data;

   logic                    rd_vld_ff;
   logic [1:0]              rd_k_ff;
   logic                    prod_vld_ff;
   logic signed [63:0]      prod_ff [4];
   logic signed [63:0]      prod_in [4];
   logic                    term_vld_ff;
   logic signed [TW-1:0]    term_ff [4];
   logic signed [TW-1:0]    term_in [4];
   logic signed [ACC_W-1:0] acc_ff [4];
   logic [2:0]              done_cnt_ff;
   logic                    acc_clear;
   logic                    rsp_load;

   logic signed [31:0]      local_rows [4];
   logic signed [31:0]      local_k;
   logic signed [31:0]      glob [4];
   logic [3:0]              sat_row;

   hts_ram #(
      .WIDTH (COL_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one parent column per read; column k scales by local row k
   assign rd_addr = {NW'(job_ff.item.parent_number), kcnt_ff};
   assign wr_addr = {NW'(job_ff.item.node_number), job_ff.item.column_number};
   assign wr_data = {glob[3], glob[2], glob[1], glob[0]};

   always_comb begin
      local_rows[0] = job_ff.item.local_row0;
      local_rows[1] = job_ff.item.local_row1;
      local_rows[2] = job_ff.item.local_row2;
      local_rows[3] = job_ff.item.local_row3;
      local_k       = local_rows[rd_k_ff];
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         prod_in[r] = job_ff.parent_ok ? $signed(rd_data[r*WW +: WW]) * local_k : 64'sd0;
         // round half up, then floor to the fraction point
         term_in[r] = TW'((prod_ff[r] + HALF) >>> FRACTION_BITS);
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sat_row[r] = 1'b0;
         if (job_ff.item.is_root) begin
            glob[r] = local_rows[r];
         end else if (acc_ff[r] > SAT_HI) begin
            glob[r]    = 32'(SAT_HI);
            sat_row[r] = 1'b1;
         end else if (acc_ff[r] < SAT_LO) begin
            glob[r]    = 32'(SAT_LO);
            sat_row[r] = 1'b1;
         end else begin
            glob[r] = 32'(acc_ff[r]);
         end
      end
      rsp_in.out_node    = job_ff.item.node_number;
      rsp_in.out_column  = job_ff.item.column_number;
      rsp_in.global_row0 = glob[0];
      rsp_in.global_row1 = glob[1];
      rsp_in.global_row2 = glob[2];
      rsp_in.global_row3 = glob[3];
      rsp_in.saturated   = |sat_row;
   end

   always_comb begin
      state_in  = state_ff;
      kcnt_in   = kcnt_ff;
      job_pop   = 1'b0;
      acc_clear = 1'b0;
      rd_en     = 1'b0;
      rsp_load  = 1'b0;
      wr_en     = 1'b0;
      unique case (state_ff)
         hts_pkg::BK_IDLE: begin
            if (job_vld) begin
               job_pop   = 1'b1;
               acc_clear = 1'b1;
               kcnt_in   = 2'd0;
               state_in  = job.item.is_root ? hts_pkg::BK_DONE : hts_pkg::BK_ISSUE;
            end
         end
         hts_pkg::BK_ISSUE: begin
            rd_en   = 1'b1;
            kcnt_in = kcnt_ff + 2'd1;
            if (kcnt_ff == 2'd3) begin
               state_in = hts_pkg::BK_WAIT;
            end
         end
         hts_pkg::BK_WAIT: begin
            if (done_cnt_ff == TERMS) begin
               state_in = hts_pkg::BK_DONE;
            end
         end
         hts_pkg::BK_DONE: begin
            if (!rsp_vld_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               wr_en    = job_ff.node_ok;
               state_in = hts_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = hts_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hts_pkg::BK_IDLE;
         kcnt_ff     <= 2'd0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         term_vld_ff <= 1'b0;
         done_cnt_ff <= 3'd0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         kcnt_ff     <= kcnt_in;
         rd_vld_ff   <= rd_en;
         prod_vld_ff <= rd_vld_ff;
         term_vld_ff <= prod_vld_ff;
         if (acc_clear) begin
            done_cnt_ff <= 3'd0;
         end else if (term_vld_ff) begin
            done_cnt_ff <= done_cnt_ff + 3'd1;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job;
      end
      rd_k_ff <= kcnt_ff;
      for (int r = 0; r < 4; r++) begin
         prod_ff[r] <= prod_in[r];
         term_ff[r] <= term_in[r];
         if (acc_clear) begin
            acc_ff[r] <= '0;
         end else if (term_vld_ff) begin
            acc_ff[r] <= acc_ff[r] + ACC_W'(term_ff[r]);
         end
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for hierarchy_transform_solver: column-by-column forward kinematics.
// Depends on hts_pkg and the solver RTL; keeps its own global matrix copy to predict results.

class fk_column_board;
   localparam int  FRAC        = hts_pkg::FRACTION_BITS_DEF;
   localparam int  STORE_WORDS = hts_pkg::NODE_COUNT_DEF * 16;
   localparam longint Q_MAX    = 64'sd2147483647;
   localparam longint Q_MIN    = -64'sd2147483648;

   logic signed [31:0] global_words [STORE_WORDS];
   hts_pkg::rsp_type   expected_columns [$];
   int unsigned        mismatches;

   function new();
      mismatches = 0;
   endfunction

   // global column = parent global matrix * local column, round half up per term
   function void predict_global_column(hts_pkg::req_type it);
      logic signed [31:0] loc_col [4];
      logic signed [31:0] glob_col [4];
      longint             acc;
      longint             prod;
      int                 base;
      logic               sat;
      hts_pkg::rsp_type   want;

      loc_col[0] = it.local_row0;
      loc_col[1] = it.local_row1;
      loc_col[2] = it.local_row2;
      loc_col[3] = it.local_row3;
      sat = 1'b0;
      if (it.is_root) begin
         glob_col = loc_col;
      end else begin
         // whole parent read before the store write, so a self-parent sees old data
         base = int'(it.parent_number) * 16;
         for (int r = 0; r < 4; r++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) begin
               prod = longint'(global_words[base + k * 4 + r]) * longint'(loc_col[k]);
               prod = prod + (64'sd1 <<< (FRAC - 1));
               acc  = acc + (prod >>> FRAC);
            end
            if (acc > Q_MAX) begin
               acc = Q_MAX;
               sat = 1'b1;
            end else if (acc < Q_MIN) begin
               acc = Q_MIN;
               sat = 1'b1;
            end
            glob_col[r] = acc[31:0];
         end
      end
      for (int r = 0; r < 4; r++)
         global_words[int'(it.node_number) * 16 + int'(it.column_number) * 4 + r] = glob_col[r];

      want.out_node    = it.node_number;
      want.out_column  = it.column_number;
      want.global_row0 = glob_col[0];
      want.global_row1 = glob_col[1];
      want.global_row2 = glob_col[2];
      want.global_row3 = glob_col[3];
      want.saturated   = sat;
      expected_columns = {expected_columns, want};
   endfunction

   function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_global_column(hts_pkg::rsp_type got);
      hts_pkg::rsp_type want;

      if (expected_columns.size() == 0) begin
         $display("%0t: unexpected column, expected none, got %h", $time, got);
         mismatches++;
      end else begin
         want = expected_columns.pop_front();
         compare_field("out_node", 32'(want.out_node), 32'(got.out_node));
         compare_field("out_column", 32'(want.out_column), 32'(got.out_column));
         compare_field("global_row0", want.global_row0, got.global_row0);
         compare_field("global_row1", want.global_row1, got.global_row1);
         compare_field("global_row2", want.global_row2, got.global_row2);
         compare_field("global_row3", want.global_row3, got.global_row3);
         compare_field("saturated", 32'(want.saturated), 32'(got.saturated));
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [31:0] ONE_Q   = 32'h0001_0000;
   localparam logic [31:0] Q_MAXW  = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MINW  = 32'h8000_0000;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   hts_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   hts_pkg::rsp_type rsp_data;

   fk_column_board   board;
   int unsigned      send_idle_pct;
   int unsigned      stall_pct;
   int unsigned      hold_request;
   int unsigned      cycle_count;

   // nodes whose four columns are all written may serve as parents
   bit [3:0]         cols_written [64];
   bit               listed [64];
   logic [5:0]       full_nodes [$];
   logic [5:0]       last_full;

   hierarchy_transform_solver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.predict_global_column(req_data);
         if (rsp_valid && !rsp_stall)
            board.check_global_column(rsp_data);
      end
   end

   // result side: random stall, or a long hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            rsp_stall = 1'b1;
            repeat (hold_request) @(negedge clock);
            hold_request = 0;
         end else begin
            rsp_stall = ($urandom_range(99) < stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after acceptance with valid still up
   task automatic send_column(input logic [5:0] node, input logic [5:0] parent,
                              input logic root, input logic [1:0] col,
                              input logic [31:0] r0, input logic [31:0] r1,
                              input logic [31:0] r2, input logic [31:0] r3);
      hts_pkg::req_type it;

      it.node_number   = node;
      it.parent_number = parent;
      it.is_root       = root;
      it.column_number = col;
      it.local_row0    = r0;
      it.local_row1    = r1;
      it.local_row2    = r2;
      it.local_row3    = r3;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data  = it;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);

      cols_written[node][col] = 1'b1;
      if (&cols_written[node]) begin
         last_full = node;
         if (!listed[node]) begin
            listed[node] = 1'b1;
            full_nodes   = {full_nodes, node};
         end
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (board.expected_columns.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      int unsigned pick;

      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(7))
            0: return Q_MAXW;
            1: return Q_MINW;
            2: return 32'h0;
            3: return ONE_Q;
            4: return -ONE_Q;
            5: return 32'h1;
            6: return 32'hFFFF_FFFF;
            default: return 32'h0000_8000;
         endcase
      end else if (pick < 30) begin
         return $signed($urandom) >>> $urandom_range(0, 7);
      end
      return $signed($urandom) >>> $urandom_range(12, 20);
   endfunction

   task automatic run_directed();
      send_idle_pct = 0;
      stall_pct     = 0;
      // root full of extreme values, parent field ignored
      send_column(6'd63, 6'd63, 1'b1, 2'd0, Q_MAXW, Q_MINW, Q_MAXW, Q_MINW);
      send_column(6'd63, 6'd63, 1'b1, 2'd1, Q_MINW, Q_MAXW, 32'h0, 32'hFFFF_FFFF);
      send_column(6'd63, 6'd63, 1'b1, 2'd2, Q_MAXW, Q_MAXW, Q_MINW, 32'h1);
      send_column(6'd63, 6'd63, 1'b1, 2'd3, 32'h0, Q_MINW, Q_MAXW, Q_MAXW);
      // identity root, child straight after its last column
      send_column(6'd0, 6'h2A, 1'b1, 2'd0, ONE_Q, 32'h0, 32'h0, 32'h0);
      send_column(6'd0, 6'h15, 1'b1, 2'd1, 32'h0, ONE_Q, 32'h0, 32'h0);
      send_column(6'd0, 6'h3F, 1'b1, 2'd2, 32'h0, 32'h0, ONE_Q, 32'h0);
      send_column(6'd0, 6'h00, 1'b1, 2'd3, 32'h0, 32'h0, 32'h0, ONE_Q);
      send_column(6'd1, 6'd0, 1'b0, 2'd0, Q_MAXW, Q_MINW, 32'h0001_8000, 32'hFFFE_8000);
      send_column(6'd1, 6'd0, 1'b0, 2'd3, 32'hFFFF_FFFF, 32'h1, 32'h8000, 32'hFFFF_8000);
      // saturation high and low, then a zero column
      send_column(6'd2, 6'd63, 1'b0, 2'd0, Q_MAXW, Q_MAXW, Q_MAXW, Q_MAXW);
      send_column(6'd2, 6'd63, 1'b0, 2'd1, Q_MINW, Q_MAXW, 32'h0, 32'h0);
      send_column(6'd2, 6'd63, 1'b0, 2'd2, 32'h0, 32'h0, 32'h0, 32'h0);
      // smallest step on the diagonal: rounding of exact halves
      send_column(6'd3, 6'd5, 1'b1, 2'd0, 32'h1, 32'h0, 32'h0, 32'h0);
      send_column(6'd3, 6'd5, 1'b1, 2'd1, 32'h0, 32'h1, 32'h0, 32'h0);
      send_column(6'd3, 6'd5, 1'b1, 2'd2, 32'h0, 32'h0, 32'h1, 32'h0);
      send_column(6'd3, 6'd5, 1'b1, 2'd3, 32'h0, 32'h0, 32'h0, 32'h1);
      send_column(6'd4, 6'd3, 1'b0, 2'd0, 32'h8000, 32'hFFFF_8000, 32'hFFFF_7FFF, 32'h7FFF);
      send_column(6'd4, 6'd3, 1'b0, 2'd1, Q_MINW, Q_MAXW, 32'hFFFF_FFFF, 32'h1);
      // node as its own parent
      send_column(6'd0, 6'd0, 1'b0, 2'd2, 32'h0, 32'h0, 32'h0002_0000, 32'h0);
      send_column(6'd0, 6'd0, 1'b0, 2'd3, ONE_Q, ONE_Q, ONE_Q, ONE_Q);
   endtask

   // one node's columns, mostly complete and in order, sometimes shuffled or partial
   task automatic send_node_sequence(output int unsigned count);
      logic [5:0]  node;
      logic [5:0]  parent;
      logic        root;
      logic [1:0]  col;
      int unsigned kind;
      int unsigned ncols;

      node = 6'($urandom_range(63));
      root = (full_nodes.size() == 0) || ($urandom_range(99) < 25);
      if (root)
         parent = 6'($urandom_range(63));
      else if ($urandom_range(99) < 40)
         parent = last_full;
      else
         parent = full_nodes[$urandom_range(full_nodes.size() - 1)];
      kind  = $urandom_range(99);
      ncols = (kind < 88) ? 4 : $urandom_range(1, 3);
      for (int i = 0; i < ncols; i++) begin
         col = (kind < 75) ? 2'(i) : 2'($urandom_range(3));
         send_column(node, parent, root, col, rand_word(), rand_word(), rand_word(),
                     rand_word());
      end
      count = ncols;
   endtask

   task automatic run_phase(input int unsigned idle, input int unsigned stall,
                            input int unsigned items);
      int unsigned sent;
      int unsigned n;

      send_idle_pct = idle;
      stall_pct     = stall;
      sent          = 0;
      while (sent < items) begin
         send_node_sequence(n);
         sent += n;
      end
   endtask

   initial begin
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_request  = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_phase(0, 0, 250);
      run_phase(55, 0, 200);
      run_phase(0, 55, 200);
      run_phase(22, 22, 200);

      // long receiver hold-off while items keep coming, then a full drain
      stall_pct    = 0;
      hold_request = 300;
      run_phase(0, 0, 80);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case ($urandom_range(3))
            0: run_phase(0, 0, 20);
            1: run_phase(55, 0, 20);
            2: run_phase(0, 55, 20);
            default: run_phase(22, 22, 20);
         endcase
      end

      wait_drained();
      stall_pct = 0;
      repeat (TAIL_CYCLES) @(negedge clock);
      if (board.expected_columns.size() != 0) begin
         $display("%0t: %0d expected columns never arrived", $time,
                  board.expected_columns.size());
         board.mismatches++;
      end
      if (board.mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

[sim.f]
rtl/hts_pkg.sv
rtl/hts_ram.sv
rtl/hts_front.sv
rtl/hts_back.sv
rtl/hierarchy_transform_solver.sv
verif/tb_top.sv
